[sv/fpc_pkg.sv]
// ----------------------------------------------------------------------------
// fpc_pkg : shared types and helpers for the frame field and error checker
// Holds the frame record passed from front to back, the result layout,
// the check mode and verdict codes, and the bytewise popcount and crc-8.
// ----------------------------------------------------------------------------
package fpc_pkg;

    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam logic [2:0] MODE_EVEN = 3'd0;
    localparam logic [2:0] MODE_ODD  = 3'd1;
    localparam logic [2:0] MODE_CRC  = 3'd2;
    localparam logic [2:0] MODE_SUM  = 3'd4;

    localparam logic [7:0] HEADER_BYTES = 8'd3;

    typedef enum logic [1:0] {
        VERDICT_GOOD     = 2'd0,
        VERDICT_DAMAGED  = 2'd1,
        VERDICT_UNJUDGED = 2'd2,
        VERDICT_UNKNOWN  = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [7:0]  header;
        logic [6:0]  length;
        logic [7:0]  sender;
        logic [7:0]  receiver;
        logic [7:0]  trailer;
        logic [10:0] ones;
        logic [23:0] sum;
        logic [7:0]  crc;
        logic        crc_bad;
    } rec_t;

    typedef struct packed {
        logic [1:0]  language;
        logic [6:0]  payload_length;
        logic [1:0]  sender_group;
        logic [5:0]  sender_user;
        logic [1:0]  receiver_group;
        logic [5:0]  receiver_user;
        logic [1:0]  routing;
        logic [1:0]  flow_control;
        logic [2:0]  check_mode;
        logic [10:0] ones_count;
        logic [15:0] check_value;
        verdict_t    verdict;
    } res_t;

    function automatic logic [3:0] popcount8(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++)
        begin
            n = n + {3'b000, b[k]};
        end
        return n;
    endfunction

    // msb first, zero initial value, no final xor
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[sv/fpc_front.sv]
// ----------------------------------------------------------------------------
// fpc_front : byte intake and frame tracking
// Follows the byte position, captures header and trailer bytes, keeps the
// ones count, checksum and crc running, and writes one record per frame.
// ----------------------------------------------------------------------------
module fpc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [7:0]    frame_byte,
    input  logic          q_full,
    output logic          q_wr,
    output fpc_pkg::rec_t q_rec
);
    import fpc_pkg::*;

    logic [7:0]  pos_reg;
    logic [7:0]  pos_next;
    logic [6:0]  len_reg;
    logic [6:0]  len_next;
    logic [7:0]  header_reg;
    logic [7:0]  header_next;
    logic [7:0]  sender_reg;
    logic [7:0]  sender_next;
    logic [7:0]  receiver_reg;
    logic [7:0]  receiver_next;
    logic [7:0]  trailer_reg;
    logic [7:0]  trailer_next;
    logic [10:0] ones_reg;
    logic [10:0] ones_next;
    logic [23:0] sum_reg;
    logic [23:0] sum_next;
    logic [7:0]  hold_reg;
    logic [7:0]  hold_next;
    logic [7:0]  crc_reg;
    logic [7:0]  crc_next;

    logic        take;
    logic [6:0]  len_cur;
    logic [7:0]  trailer_pos;
    logic        at_crc_byte;
    logic        at_trailer;
    logic        done;
    logic [10:0] ones_acc;
    logic [23:0] sum_acc;
    logic [7:0]  crc_acc;

    assign take        = push && !q_full;
    assign len_cur     = (pos_reg == 8'd0) ? {frame_byte[5:0], 1'b0} : len_reg;
    assign trailer_pos = {1'b0, len_cur} + HEADER_BYTES;
    assign at_crc_byte = pos_reg > trailer_pos;
    assign at_trailer  = pos_reg == trailer_pos;
    assign done        = at_crc_byte || (at_trailer && (frame_byte[3:1] != MODE_CRC));

    assign ones_acc = ones_reg + {7'd0, popcount8(frame_byte)};
    assign sum_acc  = pos_reg[0] ? (sum_reg + {8'd0, hold_reg, frame_byte}) : sum_reg;
    assign crc_acc  = crc8_byte(crc_reg, frame_byte);

    always_comb
    begin
        pos_next      = pos_reg;
        len_next      = len_reg;
        header_next   = header_reg;
        sender_next   = sender_reg;
        receiver_next = receiver_reg;
        trailer_next  = trailer_reg;
        ones_next     = ones_reg;
        sum_next      = sum_reg;
        hold_next     = hold_reg;
        crc_next      = crc_reg;
        q_wr          = 1'b0;

        q_rec.header   = header_reg;
        q_rec.length   = len_reg;
        q_rec.sender   = sender_reg;
        q_rec.receiver = receiver_reg;
        q_rec.trailer  = at_crc_byte ? trailer_reg : frame_byte;
        q_rec.ones     = at_crc_byte ? ones_reg : ones_acc;
        q_rec.sum      = at_crc_byte ? sum_reg : sum_acc;
        q_rec.crc      = crc_reg;
        q_rec.crc_bad  = frame_byte != crc_reg;

        if (take)
        begin
            if (done)
            begin
                q_wr          = 1'b1;
                pos_next      = 8'd0;
                len_next      = 7'd0;
                header_next   = 8'd0;
                sender_next   = 8'd0;
                receiver_next = 8'd0;
                trailer_next  = 8'd0;
                ones_next     = 11'd0;
                sum_next      = 24'd0;
                hold_next     = 8'd0;
                crc_next      = 8'd0;
            end
            else
            begin
                pos_next  = pos_reg + 8'd1;
                len_next  = len_cur;
                ones_next = ones_acc;
                sum_next  = sum_acc;
                crc_next  = crc_acc;
                if (!pos_reg[0])
                    hold_next = frame_byte;
                if (pos_reg == 8'd0)
                    header_next = frame_byte;
                if (pos_reg == 8'd1)
                    sender_next = frame_byte;
                if (pos_reg == 8'd2)
                    receiver_next = frame_byte;
                if (at_trailer)
                    trailer_next = frame_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 8'd0;
            len_reg      <= 7'd0;
            header_reg   <= 8'd0;
            sender_reg   <= 8'd0;
            receiver_reg <= 8'd0;
            trailer_reg  <= 8'd0;
            ones_reg     <= 11'd0;
            sum_reg      <= 24'd0;
            hold_reg     <= 8'd0;
            crc_reg      <= 8'd0;
        end
        else
        begin
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            header_reg   <= header_next;
            sender_reg   <= sender_next;
            receiver_reg <= receiver_next;
            trailer_reg  <= trailer_next;
            ones_reg     <= ones_next;
            sum_reg      <= sum_next;
            hold_reg     <= hold_next;
            crc_reg      <= crc_next;
        end
    end

    // a frame never ends inside its three header bytes
    a_done_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr |-> (pos_reg >= HEADER_BYTES))
        else $error("frame closed before trailer position");

    a_restart_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr |=> (pos_reg == 8'd0) && (ones_reg == 11'd0) && (crc_reg == 8'd0))
        else $error("state not cleared after frame end");

endmodule

[sv/fpc_queue.sv]
// ----------------------------------------------------------------------------
// fpc_queue : frame record queue
// Short register queue between the byte intake and the verdict stage.
// ----------------------------------------------------------------------------
module fpc_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  fpc_pkg::rec_t wr_rec,
    input  logic          rd,
    output fpc_pkg::rec_t rd_rec,
    output logic          full,
    output logic          not_empty
);
    import fpc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rec_t          slot_reg [DEPTH];
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] wptr_next;
    logic [PW-1:0] rptr_reg;
    logic [PW-1:0] rptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full      = count_reg == CW'(DEPTH);
    assign not_empty = count_reg != '0;
    assign rd_rec    = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (wr)
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        if (rd)
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        if (wr && !rd)
            count_next = count_reg + CW'(1);
        else if (rd && !wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            slot_reg[wptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> !full)
        else $error("record written into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> not_empty)
        else $error("record read from an empty queue");

endmodule

[sv/fpc_back.sv]
// ----------------------------------------------------------------------------
// fpc_back : verdict and result register
// Folds the checksum, judges parity and crc, and holds one result for
// the downstream side.
// ----------------------------------------------------------------------------
module fpc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_not_empty,
    input  fpc_pkg::rec_t q_rec,
    output logic          q_rd,
    input  logic          pop,
    output logic          empty,
    output fpc_pkg::res_t res
);
    import fpc_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    res_t        res_reg;
    res_t        res_next;

    logic [2:0]  mode;
    logic [16:0] fold1;
    logic [15:0] fold2;

    assign mode  = q_rec.trailer[3:1];
    assign fold1 = {1'b0, q_rec.sum[15:0]} + {9'd0, q_rec.sum[23:16]};
    assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

    assign q_rd  = q_not_empty && (!valid_reg || pop);
    assign empty = !valid_reg;
    assign res   = res_reg;

    always_comb
    begin
        res_next.language       = q_rec.header[7:6];
        res_next.payload_length = q_rec.length;
        res_next.sender_group   = q_rec.sender[7:6];
        res_next.sender_user    = q_rec.sender[5:0];
        res_next.receiver_group = q_rec.receiver[7:6];
        res_next.receiver_user  = q_rec.receiver[5:0];
        res_next.routing        = q_rec.trailer[7:6];
        res_next.flow_control   = q_rec.trailer[5:4];
        res_next.check_mode     = mode;
        res_next.ones_count     = q_rec.ones;
        res_next.check_value    = 16'd0;
        res_next.verdict        = VERDICT_UNKNOWN;
        case (mode)
            MODE_EVEN:
            begin
                res_next.verdict = q_rec.ones[0] ? VERDICT_DAMAGED : VERDICT_GOOD;
            end
            MODE_ODD:
            begin
                res_next.verdict = q_rec.ones[0] ? VERDICT_GOOD : VERDICT_DAMAGED;
            end
            MODE_CRC:
            begin
                res_next.check_value = {8'd0, q_rec.crc};
                res_next.verdict     = q_rec.crc_bad ? VERDICT_DAMAGED : VERDICT_GOOD;
            end
            MODE_SUM:
            begin
                res_next.check_value = ~fold2;
                res_next.verdict     = VERDICT_UNJUDGED;
            end
            default:
            begin
                res_next.verdict = VERDICT_UNKNOWN;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (q_rd)
            valid_next = 1'b1;
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // a record leaves the queue only into a free or freeing result slot
    a_slot_free_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> (!valid_reg || pop))
        else $error("result overwritten before it was taken");

    a_slot_filled_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |=> valid_reg)
        else $error("result slot not filled after queue read");

endmodule

[sv/frame_field_and_error_check.sv]
// ----------------------------------------------------------------------------
// frame_field_and_error_check : frame field extraction and error check
// Takes a frame a byte at a time and returns its header and trailer fields
// with a parity or crc-8 verdict or a checksum value at each frame's end.
//
//   channel   direction  handshake     payload
//   bytes     in         push / full   frame_byte
//   results   out        pop / empty   language .. verdict
//
// one byte is taken per cycle while full is low; bytes keep flowing while a
// result waits, as records go through a short queue to the verdict stage.
// a frame's record passes through a queue slot, then the result register.
// full rises when the queue fills; above depth one the result slot is held.
// reset clears the byte position, accumulators, queue and result slot.
// ----------------------------------------------------------------------------
module frame_field_and_error_check #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  frame_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  language,
    output logic [6:0]  payload_length,
    output logic [1:0]  sender_group,
    output logic [5:0]  sender_user,
    output logic [1:0]  receiver_group,
    output logic [5:0]  receiver_user,
    output logic [1:0]  routing,
    output logic [1:0]  flow_control,
    output logic [2:0]  check_mode,
    output logic [10:0] ones_count,
    output logic [15:0] check_value,
    output logic [1:0]  verdict
);
    import fpc_pkg::*;

    logic q_wr;
    logic q_rd;
    logic q_full;
    logic q_not_empty;
    rec_t wr_rec;
    rec_t rd_rec;
    res_t res;

    fpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .frame_byte (frame_byte),
        .q_full     (q_full),
        .q_wr       (q_wr),
        .q_rec      (wr_rec)
    );

    fpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_wr),
        .wr_rec    (wr_rec),
        .rd        (q_rd),
        .rd_rec    (rd_rec),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    fpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_rec       (rd_rec),
        .q_rd        (q_rd),
        .pop         (pop),
        .empty       (empty),
        .res         (res)
    );

    assign full           = q_full;
    assign language       = res.language;
    assign payload_length = res.payload_length;
    assign sender_group   = res.sender_group;
    assign sender_user    = res.sender_user;
    assign receiver_group = res.receiver_group;
    assign receiver_user  = res.receiver_user;
    assign routing        = res.routing;
    assign flow_control   = res.flow_control;
    assign check_mode     = res.check_mode;
    assign ones_count     = res.ones_count;
    assign check_value    = res.check_value;
    assign verdict        = res.verdict;

endmodule
